### rtl/mdf_pkg.sv
// ----------------------------------------------------------------------------
// Message deframer package
// Field widths and the result transaction type shared by the channels and RTL.
// ----------------------------------------------------------------------------
package mdf_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned ID_W   = 14;
   localparam int unsigned LEN_W  = 24;
   localparam int unsigned LCNT_W = 2;

   typedef struct packed {
      logic [ID_W-1:0]   message_id;
      logic [LEN_W-1:0]  message_length;
      logic [BYTE_W-1:0] payload_byte;
      logic              has_payload;
      logic              last;
   } rsp_payload_type;

endpackage

### rtl/mdf_req_if.sv
// ----------------------------------------------------------------------------
// Message deframer request channel
// Valid/ready channel carrying one raw stream byte per transaction.
// ----------------------------------------------------------------------------
interface mdf_req_if import mdf_pkg::*; ();

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);

endinterface

### rtl/mdf_rsp_if.sv
// ----------------------------------------------------------------------------
// Message deframer response channel
// Valid/ready channel carrying one deframed payload byte or empty marker.
// ----------------------------------------------------------------------------
interface mdf_rsp_if import mdf_pkg::*; ();

   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);

endinterface

### rtl/message_deframer_unit.sv
// ----------------------------------------------------------------------------
// Message deframer unit
// Output: a result is registered in the output register, or in the skid register while it is held.
// Throughput: 1 byte per cycle while the skid register is empty; a skid register
//   keeps input open while the output is held, req_chan.ready is registered.
// Reset: synchronous, returns the phase to the header high byte, drops output.
// ----------------------------------------------------------------------------
module message_deframer_unit import mdf_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   mdf_req_if.sink   req_chan,
   mdf_rsp_if.source rsp_chan
);

   typedef enum logic [1:0] {
      PH_HDR_HI,
      PH_HDR_LO,
      PH_LEN,
      PH_PAY
   } phase_type;

   phase_type         phase_ff, phase_in;
   logic [BYTE_W-1:0] header_high_ff, header_high_in;
   logic [ID_W-1:0]   current_id_ff, current_id_in;
   logic [LCNT_W-1:0] len_left_ff, len_left_in;
   logic [LEN_W-1:0]  len_accum_ff, len_accum_in;
   logic [LEN_W-1:0]  payload_left_ff, payload_left_in;

   logic              rsp_valid_ff;
   rsp_payload_type   rsp_data_ff;
   logic              skid_valid_ff;
   rsp_payload_type   skid_data_ff;

   logic              accept;
   logic              out_free;
   logic              emit;
   logic              has_pay;
   logic              fin;
   logic [BYTE_W-1:0] din;
   rsp_payload_type   result;

   assign din      = req_chan.data_byte;
   assign accept   = req_chan.valid & req_chan.ready;
   assign out_free = ~rsp_valid_ff | rsp_chan.ready;

   assign req_chan.ready  = ~skid_valid_ff;
   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

   always_comb begin
      phase_in        = phase_ff;
      header_high_in  = header_high_ff;
      current_id_in   = current_id_ff;
      len_left_in     = len_left_ff;
      len_accum_in    = len_accum_ff;
      payload_left_in = payload_left_ff;
      emit            = 1'b0;
      has_pay         = 1'b0;
      fin             = 1'b0;
      unique case (phase_ff)
         PH_HDR_HI: begin
            header_high_in = din;
            phase_in       = PH_HDR_LO;
         end
         PH_HDR_LO: begin
            current_id_in   = {header_high_ff, din[BYTE_W-1:LCNT_W]};
            len_left_in     = din[LCNT_W-1:0];
            len_accum_in    = '0;
            payload_left_in = '0;
            if (din[LCNT_W-1:0] == '0) begin
               emit     = 1'b1;
               fin      = 1'b1;
               phase_in = PH_HDR_HI;
            end else begin
               phase_in = PH_LEN;
            end
         end
         PH_LEN: begin
            len_accum_in = {len_accum_ff[LEN_W-BYTE_W-1:0], din};
            len_left_in  = len_left_ff - LCNT_W'(1);
            if (len_left_in == '0) begin
               if (len_accum_in == '0) begin
                  emit     = 1'b1;
                  fin      = 1'b1;
                  phase_in = PH_HDR_HI;
               end else begin
                  payload_left_in = len_accum_in;
                  phase_in        = PH_PAY;
               end
            end
         end
         PH_PAY: begin
            payload_left_in = payload_left_ff - LEN_W'(1);
            emit            = 1'b1;
            has_pay         = 1'b1;
            fin             = (payload_left_in == '0);
            if (fin) begin
               phase_in = PH_HDR_HI;
            end
         end
         default: begin
            phase_in = PH_HDR_HI;
         end
      endcase
      result.message_id     = current_id_in;
      result.message_length = len_accum_in;
      result.payload_byte   = has_pay ? din : '0;
      result.has_payload    = has_pay;
      result.last           = fin;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_HDR_HI;
         header_high_ff  <= '0;
         current_id_ff   <= '0;
         len_left_ff     <= '0;
         len_accum_ff    <= '0;
         payload_left_ff <= '0;
         rsp_valid_ff    <= 1'b0;
         skid_valid_ff   <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff        <= phase_in;
            header_high_ff  <= header_high_in;
            current_id_ff   <= current_id_in;
            len_left_ff     <= len_left_in;
            len_accum_ff    <= len_accum_in;
            payload_left_ff <= payload_left_in;
         end
         if (out_free) begin
            if (skid_valid_ff) begin
               rsp_valid_ff  <= 1'b1;
               skid_valid_ff <= 1'b0;
            end else begin
               rsp_valid_ff <= accept & emit;
            end
         end else if (accept & emit) begin
            skid_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         if (skid_valid_ff) begin
            rsp_data_ff <= skid_data_ff;
         end else if (accept & emit) begin
            rsp_data_ff <= result;
         end
      end else if (accept & emit) begin
         skid_data_ff <= result;
      end
   end

   a_skid_implies_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid register holds a transaction while output is empty");

   a_pay_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAY) |-> (payload_left_ff != '0))
      else $error("payload phase with no payload bytes left");

   a_len_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_LEN) |-> (len_left_ff != '0))
      else $error("length phase with no length bytes left");

   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && rsp_chan.ready) |=> (!skid_valid_ff && rsp_valid_ff))
      else $error("skid register failed to move to output");

endmodule
